### sv/arp_responder_with_cache_core_defines.svh
// ----------------------------------------------------------------------------
// ARP responder assertion macros
// Shared property shapes for the port-level checks of the responder core.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_WITH_CACHE_CORE_DEFINES_SVH
`define ARP_RESPONDER_WITH_CACHE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ARPC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define ARPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder package
// Beat types, header constants and opcodes shared by the responder modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // input opcodes
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

  // header field values as read from the message
  localparam logic [15:0] HW_ETHERNET    = 16'h0100;
  localparam logic [15:0] PROTO_IPV4     = 16'h0008;
  localparam logic [15:0] CMD_REQUEST    = 16'h0100;
  localparam logic [15:0] CMD_REPLY      = 16'h0200;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [10:0] MIN_MSG_LEN    = 11'd28;
  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] msg_length;
    logic [15:0] hw_type;
    logic [15:0] protocol_type;
    logic [7:0]  hw_addr_size;
    logic [7:0]  proto_addr_size;
    logic [15:0] command;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arpc_in_t;

  typedef struct packed {
    logic        send_frame;
    logic [15:0] out_command;
    logic [47:0] out_sender_mac;
    logic [31:0] out_sender_ip;
    logic [47:0] out_target_mac;
    logic [31:0] out_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
  } arpc_out_t;

  // one cache line
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } arpc_entry_t;

  localparam int unsigned ENTRY_W = $bits(arpc_entry_t);

  // scan unit status back to the control
  typedef struct packed {
    logic        done;
    logic        hit;
    logic [47:0] mac;
  } arpc_scan_res_t;

endpackage

### sv/arpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/arpc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache scan unit
// Walks the cache from entry 0, one RAM read a cycle, and compares each
// returned line against the key; the first valid match ends the walk.
// ----------------------------------------------------------------------------
module arpc_scan #(
  parameter int unsigned ENTRIES = 8,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [31:0]              key,
  input  logic [ENTRIES-1:0]       valid_vec,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  arpc_pkg::arpc_entry_t    rd_data,
  output arpc_pkg::arpc_scan_res_t res
);
  import arpc_pkg::*;

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_RUN  = 2'b10
  } scan_state_t;

  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  scan_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic          run;
  logic          match;
  logic          last;

  assign run   = (state_r == SC_RUN);
  // read data in this cycle belongs to entry pidx_r
  assign match = pend_r && valid_vec[pidx_r] && (rd_data.ip == key);
  assign last  = pend_r && (pidx_r == LAST_IDX);

  assign rd_en   = run && issue_r;
  assign rd_addr = idx_r;

  always_comb begin
    res.done = run && (match || last);
    res.hit  = run && match;
    res.mac  = match ? rd_data.mac : MAC_BCAST;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    issue_nxt = issue_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      SC_IDLE: begin
        if (go) begin
          state_nxt = SC_RUN;
          idx_nxt   = '0;
          issue_nxt = 1'b1;
          pend_nxt  = 1'b0;
        end
      end
      SC_RUN: begin
        pend_nxt = issue_r;
        pidx_nxt = idx_r;
        if (issue_r) begin
          if (idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        if (res.done) begin
          state_nxt = SC_IDLE;
          issue_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
        issue_nxt = 1'b0;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
  end

endmodule

### sv/arp_responder_with_cache_core.sv
`timescale 1ns / 1ps
// Received messages and request builds pass ST_EXEC, which sets the registered out_valid;
// a lookup goes on to ST_SCAN and strobes out_valid once the scan hits or reads the last entry.
// The core takes no new item while busy; a lookup is bound by the single cache RAM read
// port, which the scan walks one entry a cycle.
// Reset (rst_n low, synchronous) clears the cache valid bits, the fill slot and own
// addresses; results are never held off, out_valid lasts one cycle.
// ----------------------------------------------------------------------------
// ARP responder core with address cache
// Checks received ARP messages, answers requests, caches replies and serves
// lookups and broadcast request builds for IPv4 over Ethernet.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_core #(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  arpc_pkg::arpc_in_t                  in_data,
  output logic                                out_valid,
  output arpc_pkg::arpc_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import arpc_pkg::*;

  localparam int unsigned AW = $clog2(CACHE_ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CACHE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  arpc_in_t item_r;
  arpc_out_t out_data_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] own_ip_r;
  logic [47:0] own_mac_r;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic accept;
  logic hdr_ok;
  logic ram_we;
  arpc_entry_t wr_entry;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_word;
  arpc_entry_t rd_entry;
  logic scan_go;
  arpc_scan_res_t scan_res;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign hdr_ok = (item_r.msg_length >= MIN_MSG_LEN) &&
                  (item_r.hw_type == HW_ETHERNET) &&
                  (item_r.protocol_type == PROTO_IPV4) &&
                  (item_r.hw_addr_size == HW_ADDR_LEN) &&
                  (item_r.proto_addr_size == PROTO_ADDR_LEN) &&
                  (item_r.target_ip == own_ip_r);

  assign wr_entry.ip  = item_r.sender_ip;
  assign wr_entry.mac = item_r.sender_mac;
  assign rd_entry     = arpc_entry_t'(rd_word);

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = '0;
    out_valid_nxt = 1'b0;
    valid_nxt     = valid_r;
    slot_nxt      = slot_r;
    ram_we        = 1'b0;
    scan_go       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (item_r.opcode)
          OP_RECEIVE: begin
            if (hdr_ok && (item_r.command == CMD_REQUEST)) begin
              out_nxt.send_frame     = 1'b1;
              out_nxt.out_command    = CMD_REPLY;
              out_nxt.out_sender_mac = own_mac_r;
              out_nxt.out_sender_ip  = own_ip_r;
              out_nxt.out_target_mac = item_r.sender_mac;
              out_nxt.out_target_ip  = item_r.sender_ip;
            end else if (hdr_ok && (item_r.command == CMD_REPLY)) begin
              // store at the round-robin slot, result stays all zero
              ram_we            = 1'b1;
              valid_nxt[slot_r] = 1'b1;
              slot_nxt          = (slot_r == LAST_SLOT) ? '0 : slot_r + AW'(1);
            end
          end
          OP_LOOKUP: begin
            state_nxt     = ST_SCAN;
            out_valid_nxt = 1'b0;
            scan_go       = 1'b1;
          end
          OP_REQUEST: begin
            out_nxt.send_frame     = 1'b1;
            out_nxt.out_command    = CMD_REQUEST;
            out_nxt.out_sender_mac = own_mac_r;
            out_nxt.out_sender_ip  = own_ip_r;
            out_nxt.out_target_mac = MAC_BCAST;
            out_nxt.out_target_ip  = item_r.target_ip;
          end
          default: begin
            // unused opcode: all-zero beat
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt          = ST_IDLE;
          out_valid_nxt      = 1'b1;
          out_nxt.lookup_hit = scan_res.hit;
          out_nxt.lookup_mac = scan_res.mac;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      slot_r      <= '0;
      own_ip_r    <= '0;
      own_mac_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      slot_r      <= slot_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OWN_IP:  own_ip_r  <= cfg_wdata[31:0];
          REG_OWN_MAC: own_mac_r <= cfg_wdata[47:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (out_valid_nxt) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  arpc_scan #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (scan_go),
    .key       (item_r.target_ip),
    .valid_vec (valid_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_entry),
    .res       (scan_res)
  );

endmodule

### sv/arpc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder port checker
// Watches the command and result ports of the responder core over time.
// ----------------------------------------------------------------------------
`include "arp_responder_with_cache_core_defines.svh"

module arpc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input arpc_pkg::arpc_out_t out_data
);
  import arpc_pkg::*;

  // a result beat always comes with the block free again
  `ARPC_ASSERT_IMPL(a_out_not_busy, out_valid, !busy, "result beat while busy")

  // an accepted command occupies the block in the next cycle
  `ARPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

  // result beats never come back to back
  `ARPC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "two result beats in a row")

  // busy only drops together with a result beat
  `ARPC_ASSERT_IMPL(a_done_beat, $fell(busy) && $past(rst_n), out_valid && !out_data.lookup_hit || out_valid && !out_data.send_frame, "busy dropped without a result beat")

endmodule

bind arp_responder_with_cache_core arpc_chk u_arpc_chk (.*);

### tb/tb_arp_responder_with_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder core testbench
// Drives received messages, cache lookups and request builds through the
// start/busy port, mirrors the responder and its reply cache in a local
// predictor, and checks every result beat against it. Own addresses are
// rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_cache_core;
  import arpc_pkg::*;

  localparam int unsigned CACHE_ENTRIES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned PHASE_ITEMS   = 425;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  localparam logic [31:0] DIR_IP  = 32'h010A_A8C0;
  localparam logic [47:0] DIR_MAC = 48'h0211_2233_4455;
  localparam logic [31:0] IP_A    = 32'h0200_000A;
  localparam logic [47:0] MAC_A   = 48'h00AA_BBCC_DDEE;
  localparam logic [47:0] MAC_B   = 48'h0A0B_0C0D_0E0F;

  typedef struct {
    arpc_in_t  item;
    bit        typed;
    arpc_out_t result;
  } arp_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  arpc_in_t              in_data;
  logic                  out_valid;
  arpc_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [31:0] own_ip_r  = '0;
  logic [47:0] own_mac_r = '0;
  logic [31:0] cache_ip  [CACHE_ENTRIES];
  logic [47:0] cache_mac [CACHE_ENTRIES];
  bit          cache_vld [CACHE_ENTRIES];
  int unsigned fill_slot = 0;

  arpc_out_t   arp_result_q[$];
  arp_row_t    dir_rows[$];
  logic [31:0] ip_pool[12];
  arpc_out_t   want;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  arp_responder_with_cache_core #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("arp_responder_with_cache_core: mismatch");
      $finish;
    end
  end

  function automatic arpc_out_t arp_respond(arpc_in_t it);
    arpc_out_t res;
    bit        ok;
    bit        found;
    res   = '0;
    found = 1'b0;
    ok = it.msg_length >= MIN_MSG_LEN && it.hw_type == HW_ETHERNET &&
         it.protocol_type == PROTO_IPV4 && it.hw_addr_size == HW_ADDR_LEN &&
         it.proto_addr_size == PROTO_ADDR_LEN && it.target_ip == own_ip_r;
    case (it.opcode)
      OP_RECEIVE: begin
        if (ok && it.command == CMD_REQUEST) begin
          res.send_frame     = 1'b1;
          res.out_command    = CMD_REPLY;
          res.out_sender_mac = own_mac_r;
          res.out_sender_ip  = own_ip_r;
          res.out_target_mac = it.sender_mac;
          res.out_target_ip  = it.sender_ip;
        end else if (ok && it.command == CMD_REPLY) begin
          cache_ip[fill_slot]  = it.sender_ip;
          cache_mac[fill_slot] = it.sender_mac;
          cache_vld[fill_slot] = 1'b1;
          fill_slot = (fill_slot + 1) % CACHE_ENTRIES;
        end
      end
      OP_LOOKUP: begin
        res.lookup_mac = MAC_BCAST;
        // first valid entry wins
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!found && cache_vld[i] && cache_ip[i] == it.target_ip) begin
            found          = 1'b1;
            res.lookup_hit = 1'b1;
            res.lookup_mac = cache_mac[i];
          end
        end
      end
      OP_REQUEST: begin
        res.send_frame     = 1'b1;
        res.out_command    = CMD_REQUEST;
        res.out_sender_mac = own_mac_r;
        res.out_sender_ip  = own_ip_r;
        res.out_target_mac = MAC_BCAST;
        res.out_target_ip  = it.target_ip;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic arpc_in_t noise_item();
    arpc_in_t it;
    it.opcode          = 2'($urandom_range(0, 3));
    it.msg_length      = 11'($urandom);
    it.hw_type         = 16'($urandom);
    it.protocol_type   = 16'($urandom);
    it.hw_addr_size    = 8'($urandom);
    it.proto_addr_size = 8'($urandom);
    it.command         = 16'($urandom);
    it.sender_mac      = rand_mac();
    it.sender_ip       = $urandom;
    it.target_ip       = $urandom;
    return it;
  endfunction

  function automatic arpc_in_t op_item(logic [1:0] op, logic [31:0] tip);
    arpc_in_t it;
    it           = noise_item();
    it.opcode    = op;
    it.target_ip = tip;
    return it;
  endfunction

  function automatic arpc_in_t arp_msg(logic [15:0] cmd, logic [10:0] len,
                                       logic [47:0] smac, logic [31:0] sip,
                                       logic [31:0] tip);
    return '{OP_RECEIVE, len, HW_ETHERNET, PROTO_IPV4, HW_ADDR_LEN, PROTO_ADDR_LEN,
             cmd, smac, sip, tip};
  endfunction

  function automatic arpc_out_t frame_out(logic [15:0] cmd, logic [47:0] tmac,
                                          logic [31:0] tip);
    return '{1'b1, cmd, DIR_MAC, DIR_IP, tmac, tip, 1'b0, 48'h0};
  endfunction

  function automatic arpc_in_t random_arp_item();
    arpc_in_t    it;
    int unsigned pick;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [10:0] len;
    pick = $urandom_range(0, 99);
    sip  = ip_pool[$urandom_range(0, 11)];
    case ($urandom_range(0, 7))
      0:       smac = '0;
      1:       smac = MAC_BCAST;
      default: smac = rand_mac();
    endcase
    len = ($urandom_range(0, 3) == 0) ? MIN_MSG_LEN : 11'($urandom_range(28, 2047));
    if (pick < 30) begin
      it = arp_msg(CMD_REPLY, len, smac, sip, own_ip_r);
    end else if (pick < 50) begin
      it = arp_msg(CMD_REQUEST, len, smac, sip, own_ip_r);
    end else if (pick < 72) begin
      it = op_item(OP_LOOKUP, ($urandom_range(0, 9) < 7) ? sip : $urandom);
    end else if (pick < 82) begin
      it = op_item(OP_REQUEST, $urandom);
    end else if (pick < 94) begin
      // break one header field of an otherwise good message
      it = arp_msg(($urandom_range(0, 1) != 0) ? CMD_REPLY : CMD_REQUEST, len, smac, sip,
                   own_ip_r);
      case ($urandom_range(0, 7))
        0: it.msg_length      = 11'($urandom_range(0, 27));
        1: it.hw_type         = {HW_ETHERNET[7:0], HW_ETHERNET[15:8]};
        2: it.protocol_type   = {PROTO_IPV4[7:0], PROTO_IPV4[15:8]};
        3: it.hw_addr_size    = 8'($urandom);
        4: it.proto_addr_size = 8'($urandom);
        5: it.target_ip       = $urandom;
        6: it.command         = {it.command[7:0], it.command[15:8]};
        default: it.command   = 16'($urandom);
      endcase
    end else begin
      it = noise_item();
    end
    return it;
  endfunction

  task automatic add_row(arpc_in_t it, bit typed, arpc_out_t res);
    dir_rows.push_back('{it, typed, res});
  endtask

  // present one beat and hold it until the core takes it
  task automatic send_item(arpc_in_t it, bit typed, arpc_out_t typed_res);
    arpc_out_t pred;
    @(negedge clk);
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = arp_respond(it);
    arp_result_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_input(int unsigned n);
    @(negedge clk);
    start   <= 1'b0;
    in_data <= noise_item();
    repeat (n) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] ip, logic [47:0] mac);
    while (arp_result_q.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_IP;
    cfg_wdata <= {16'($urandom), ip};
    @(posedge clk);
    own_ip_r = ip;
    @(negedge clk);
    cfg_index <= REG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    own_mac_r = mac;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned n, int unsigned idle_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        idle_input($urandom_range(1, 12));
      send_item(random_arp_item(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (arp_result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %h", out_data);
      end else begin
        want = arp_result_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result mismatch (exp/got): send %b/%b cmd %h/%h smac %h/%h ",
                   want.send_frame, out_data.send_frame,
                   want.out_command, out_data.out_command,
                   want.out_sender_mac, out_data.out_sender_mac);
            $display("sip %h/%h tmac %h/%h tip %h/%h hit %b/%b mac %h/%h",
                     want.out_sender_ip, out_data.out_sender_ip,
                     want.out_target_mac, out_data.out_target_mac,
                     want.out_target_ip, out_data.out_target_ip,
                     want.lookup_hit, out_data.lookup_hit,
                     want.lookup_mac, out_data.lookup_mac);
          end
        end
      end
    end
  end

  initial begin
    arpc_in_t    it;
    logic [31:0] rnd_ip;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_OWN_IP;
    cfg_wdata = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      cache_ip[i]  = '0;
      cache_mac[i] = '0;
      cache_vld[i] = 1'b0;
    end
    ip_pool[0] = '0;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) ip_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(DIR_IP, DIR_MAC);

    // empty cache: no entry matches, not even the all-zero address
    add_row(op_item(OP_LOOKUP, IP_A), 1'b1, '{default: '0, lookup_mac: MAC_BCAST});
    add_row(op_item(OP_LOOKUP, 32'h0), 1'b1, '{default: '0, lookup_mac: MAC_BCAST});
    add_row(arp_msg(CMD_REQUEST, MIN_MSG_LEN, MAC_A, IP_A, DIR_IP), 1'b1,
            frame_out(CMD_REPLY, MAC_A, IP_A));
    add_row(arp_msg(CMD_REQUEST, MIN_MSG_LEN - 11'd1, MAC_A, IP_A, DIR_IP), 1'b1, '0);
    add_row(arp_msg(CMD_REQUEST, 11'h7FF, MAC_BCAST, 32'hFFFF_FFFF, DIR_IP), 1'b1,
            frame_out(CMD_REPLY, MAC_BCAST, 32'hFFFF_FFFF));
    it = arp_msg(CMD_REQUEST, 11'd64, MAC_A, IP_A, DIR_IP);
    it.hw_type = {HW_ETHERNET[7:0], HW_ETHERNET[15:8]};
    add_row(it, 1'b1, '0);
    it = arp_msg(CMD_REQUEST, 11'd64, MAC_A, IP_A, DIR_IP);
    it.protocol_type = {PROTO_IPV4[7:0], PROTO_IPV4[15:8]};
    add_row(it, 1'b1, '0);
    it = arp_msg(CMD_REQUEST, 11'd64, MAC_A, IP_A, DIR_IP);
    it.hw_addr_size = HW_ADDR_LEN - 8'd1;
    add_row(it, 1'b1, '0);
    it = arp_msg(CMD_REQUEST, 11'd64, MAC_A, IP_A, DIR_IP);
    it.proto_addr_size = 8'hFF;
    add_row(it, 1'b1, '0);
    add_row(arp_msg(CMD_REQUEST, 11'd64, MAC_A, IP_A, DIR_IP ^ 32'h1), 1'b1, '0);
    // good header, command neither request nor reply
    add_row(arp_msg(16'h0300, 11'd64, MAC_A, IP_A, DIR_IP), 1'b1, '0);
    add_row(arp_msg({CMD_REPLY[7:0], CMD_REPLY[15:8]}, 11'd64, MAC_A, IP_A, DIR_IP),
            1'b1, '0);
    // a reply fills the cache and answers nothing
    add_row(arp_msg(CMD_REPLY, 11'd46, MAC_A, IP_A, DIR_IP), 1'b1, '0);
    add_row(op_item(OP_LOOKUP, IP_A), 1'b0, '0);
    add_row(arp_msg(CMD_REPLY, 11'd46, MAC_B, IP_A, DIR_IP), 1'b1, '0);
    add_row(op_item(OP_LOOKUP, IP_A), 1'b0, '0);
    add_row(arp_msg(CMD_REPLY, MIN_MSG_LEN, 48'h0, 32'h0, DIR_IP), 1'b1, '0);
    add_row(op_item(OP_LOOKUP, 32'h0), 1'b0, '0);
    add_row(arp_msg(CMD_REPLY, 11'h7FF, MAC_BCAST, 32'hFFFF_FFFF, DIR_IP), 1'b1, '0);
    add_row(op_item(OP_LOOKUP, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(op_item(OP_REQUEST, 32'h0), 1'b1, frame_out(CMD_REQUEST, MAC_BCAST, 32'h0));
    add_row(op_item(OP_REQUEST, 32'hFFFF_FFFF), 1'b1,
            frame_out(CMD_REQUEST, MAC_BCAST, 32'hFFFF_FFFF));
    add_row('{OP_UNUSED, 11'h7FF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, MAC_BCAST,
              32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0);
    add_row(op_item(OP_UNUSED, DIR_IP), 1'b1, '0);
    add_row('{OP_RECEIVE, 11'h7FF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, MAC_BCAST,
              32'hFFFF_FFFF, DIR_IP}, 1'b1, '0);

    foreach (dir_rows[k]) begin
      if ($urandom_range(0, 4) == 0) idle_input($urandom_range(1, 12));
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].result);
    end

    // phases: reset-value addresses, all ones, then random ones
    idle_input(1);
    set_config('0, '0);
    run_random(PHASE_ITEMS, 30);
    idle_input(1);
    set_config(32'hFFFF_FFFF, MAC_BCAST);
    run_random(PHASE_ITEMS, 60);
    idle_input(1);
    rnd_ip = $urandom;
    set_config(rnd_ip, rand_mac());
    run_random(PHASE_ITEMS, 15);
    idle_input(1);
    rnd_ip = $urandom;
    set_config(rnd_ip, rand_mac());
    run_random(PHASE_ITEMS, 0);
    idle_input(1);

    while (arp_result_q.size() != 0) @(posedge clk);
    repeat (CACHE_ENTRIES + 6) @(posedge clk);
    if (mismatches == 0 && arp_result_q.size() == 0) begin
      $display("arp_responder_with_cache_core: match");
    end else begin
      $display("arp_responder_with_cache_core: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arpc_scan.sv
sv/arp_responder_with_cache_core.sv
sv/arpc_chk.sv
tb/tb_arp_responder_with_cache_core.sv
